// ===== src/cset_pkg.sv =====
// Shared types, constants and helpers of the call-stack exclusive-time profiler.
package cset_pkg;

  localparam int NUM_FUNCS   = 256;
  localparam int STACK_DEPTH = 64;

  localparam int FUNC_W   = 8;
  localparam int STAMP_W  = 32;
  localparam int EXCL_W   = STAMP_W + 1;
  localparam int TOTAL_W  = 48;
  localparam int STATUS_W = 2;

  localparam int ROW_W = (NUM_FUNCS > 1) ? $clog2(NUM_FUNCS) : 1;
  localparam int SP_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int LVL_W = $clog2(STACK_DEPTH + 1);

  localparam logic OP_START = 1'b0;
  localparam logic OP_END   = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_OVER  = 2'd1,
    ST_UNDER = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_STACK,
    S_TABLE
  } state_e;

  // One stack entry; parent_sub holds the subcall time of the entry below it.
  typedef struct packed {
    logic [FUNC_W-1:0]  func_id;
    logic [STAMP_W-1:0] start;
    logic [EXCL_W-1:0]  parent_sub;
  } stk_entry_t;

  typedef struct packed {
    logic               push;
    logic               pop;
    logic [FUNC_W-1:0]  func_id;
    logic [STAMP_W-1:0] stamp;
  } stk_cmd_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [FUNC_W-1:0] done_id;
    logic [EXCL_W-1:0] excl;
  } stk_res_t;

  typedef struct packed {
    logic             rd;
    logic             wr;
    logic [ROW_W-1:0] row;
  } tbl_cmd_t;

  function automatic logic [ROW_W-1:0] func_row(input logic [FUNC_W-1:0] id);
    return ROW_W'(32'(id) % NUM_FUNCS);
  endfunction

endpackage

// ===== src/cset_if.sv =====
// Event and result channel interfaces of the profiler.
interface cset_evt_if;
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic [cset_pkg::FUNC_W-1:0]  func_id;
  logic [cset_pkg::STAMP_W-1:0] stamp;

  modport source (output valid, op, func_id, stamp, input ready);
  modport sink   (input valid, op, func_id, stamp, output ready);
endinterface

interface cset_res_if;
  logic                         valid;
  logic                         ready;
  logic [cset_pkg::FUNC_W-1:0]   done_id;
  logic [cset_pkg::EXCL_W-1:0]   call_exclusive;
  logic [cset_pkg::TOTAL_W-1:0]  running_total;
  logic [cset_pkg::STATUS_W-1:0] status;

  modport source (output valid, done_id, call_exclusive, running_total, status, input ready);
  modport sink   (input valid, done_id, call_exclusive, running_total, status, output ready);
endinterface

// ===== src/cset_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cset_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== src/cset_stack.sv =====
// Call stack: entry memory, fill level and the subcall accumulator of the top call.
module cset_stack (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cset_pkg::stk_cmd_t  cmd_i,
  output cset_pkg::stk_res_t  res_o
);

  localparam int EntryW = $bits(cset_pkg::stk_entry_t);

  logic [cset_pkg::LVL_W-1:0]   level_q, level_d;
  logic [cset_pkg::LVL_W-1:0]   top_lvl;
  logic [cset_pkg::EXCL_W-1:0]  top_sub_q, top_sub_d;
  logic [cset_pkg::STAMP_W-1:0] stamp_q;
  logic                         pop_q;
  cset_pkg::stk_entry_t         wr_entry;
  cset_pkg::stk_entry_t         rd_entry;
  logic [EntryW-1:0]            rd_raw;
  logic [cset_pkg::STAMP_W-1:0] diff;
  logic [cset_pkg::EXCL_W-1:0]  incl;
  logic [cset_pkg::EXCL_W:0]    parent_sum;

  assign top_lvl = level_q - cset_pkg::LVL_W'(1);

  // The old top's subcall time moves into the new entry on a push and
  // comes back into the accumulator on the matching pop.
  assign wr_entry.func_id    = cmd_i.func_id;
  assign wr_entry.start      = cmd_i.stamp;
  assign wr_entry.parent_sub = top_sub_q;

  cset_ram #(
    .WIDTH (EntryW),
    .DEPTH (cset_pkg::STACK_DEPTH)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push),
    .waddr_i (level_q[cset_pkg::SP_W-1:0]),
    .wdata_i (wr_entry),
    .re_i    (cmd_i.pop),
    .raddr_i (top_lvl[cset_pkg::SP_W-1:0]),
    .rdata_o (rd_raw)
  );

  assign rd_entry = cset_pkg::stk_entry_t'(rd_raw);

  assign diff       = stamp_q - rd_entry.start;
  assign incl       = {1'b0, diff} + cset_pkg::EXCL_W'(1);
  assign parent_sum = {1'b0, rd_entry.parent_sub} + {1'b0, incl};

  always_comb begin
    level_d   = level_q;
    top_sub_d = top_sub_q;
    if (cmd_i.push) begin
      level_d   = level_q + cset_pkg::LVL_W'(1);
      top_sub_d = '0;
    end else if (cmd_i.pop) begin
      level_d = top_lvl;
    end
    if (pop_q) begin
      top_sub_d = parent_sum[cset_pkg::EXCL_W] ? '1 : parent_sum[cset_pkg::EXCL_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q   <= '0;
      top_sub_q <= '0;
      pop_q     <= 1'b0;
    end else begin
      level_q   <= level_d;
      top_sub_q <= top_sub_d;
      pop_q     <= cmd_i.pop;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pop) begin
      stamp_q <= cmd_i.stamp;
    end
  end

  assign res_o.full    = (level_q == cset_pkg::LVL_W'(cset_pkg::STACK_DEPTH));
  assign res_o.empty   = (level_q == '0);
  assign res_o.done_id = rd_entry.func_id;
  assign res_o.excl    = (top_sub_q > incl) ? '0 : (incl - top_sub_q);

`ifndef NO_ASSERTIONS
  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= cset_pkg::LVL_W'(cset_pkg::STACK_DEPTH))
    else $error("stack level beyond depth");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> !res_o.full && !cmd_i.pop)
    else $error("push on full stack or together with pop");
`endif

endmodule

// ===== src/cset_total.sv =====
// Exclusive-time table: per-function totals in memory with saturating update.
module cset_total (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cset_pkg::tbl_cmd_t           cmd_i,
  input  logic [cset_pkg::EXCL_W-1:0]  excl_i,
  output logic [cset_pkg::TOTAL_W-1:0] total_o
);

  logic [cset_pkg::NUM_FUNCS-1:0] vld_q;
  logic [cset_pkg::ROW_W-1:0]     row_q;
  logic [cset_pkg::TOTAL_W-1:0]   rdata;
  logic [cset_pkg::TOTAL_W-1:0]   old_total;
  logic [cset_pkg::TOTAL_W:0]     sum;

  cset_ram #(
    .WIDTH (cset_pkg::TOTAL_W),
    .DEPTH (cset_pkg::NUM_FUNCS)
  ) u_total_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr),
    .waddr_i (row_q),
    .wdata_i (total_o),
    .re_i    (cmd_i.rd),
    .raddr_i (cmd_i.row),
    .rdata_o (rdata)
  );

  // A row never written since reset reads as zero.
  assign old_total = vld_q[row_q] ? rdata : '0;
  assign sum       = {1'b0, old_total} + (cset_pkg::TOTAL_W + 1)'(excl_i);
  assign total_o   = sum[cset_pkg::TOTAL_W] ? '1 : sum[cset_pkg::TOTAL_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (cmd_i.wr) begin
      vld_q[row_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      row_q <= cmd_i.row;
    end
  end

endmodule

// ===== src/call_stack_exclusive_time.sv =====
// Top level of the call-stack exclusive-time profiler.
// A start event that fits on the stack is taken in the idle state and gives no result; the
// next event can follow in the next cycle. An end event, a start on a full stack and an
// end on an empty stack each hold off the next event while the stack memory is read, then
// while the call times are computed and the totals memory is read, and then while the
// updated total is written and the result beat is loaded. The last of these waits
// while a previous result beat is still held. Totals read as zero after reset without
// any clearing pass. Stack depth is 64 calls and the totals table has 256 rows.
module call_stack_exclusive_time (
  input  logic     clk_i,
  input  logic     rst_ni,
  cset_evt_if.sink   evt_i,
  cset_res_if.source res_o
);

  cset_pkg::state_e  state_q, state_d;
  cset_pkg::status_e status_q, status_d;
  cset_pkg::stk_cmd_t stk_cmd;
  cset_pkg::stk_res_t stk_res;
  cset_pkg::tbl_cmd_t tbl_cmd;

  logic                          evt_acc;
  logic                          slot_free;
  logic                          load_res;
  logic [cset_pkg::FUNC_W-1:0]   id_q, id_d;
  logic [cset_pkg::EXCL_W-1:0]   excl_q, excl_d;
  logic [cset_pkg::TOTAL_W-1:0]  total;

  logic                          out_vld_q;
  logic [cset_pkg::FUNC_W-1:0]   out_id_q;
  logic [cset_pkg::EXCL_W-1:0]   out_excl_q;
  logic [cset_pkg::TOTAL_W-1:0]  out_total_q;
  logic [cset_pkg::STATUS_W-1:0] out_status_q;

  assign evt_acc   = evt_i.valid && evt_i.ready;
  assign slot_free = !out_vld_q || res_o.ready;

  cset_stack u_stack (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (stk_cmd),
    .res_o  (stk_res)
  );

  cset_total u_total (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (tbl_cmd),
    .excl_i  (excl_q),
    .total_o (total)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cset_pkg::S_IDLE: begin
        if (evt_acc && (evt_i.op == cset_pkg::OP_END || stk_res.full)) begin
          state_d = cset_pkg::S_STACK;
        end
      end
      cset_pkg::S_STACK: state_d = cset_pkg::S_TABLE;
      cset_pkg::S_TABLE: begin
        if (slot_free) begin
          state_d = cset_pkg::S_IDLE;
        end
      end
      default: state_d = cset_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    evt_i.ready     = 1'b0;
    stk_cmd.push    = 1'b0;
    stk_cmd.pop     = 1'b0;
    stk_cmd.func_id = evt_i.func_id;
    stk_cmd.stamp   = evt_i.stamp;
    tbl_cmd.rd      = 1'b0;
    tbl_cmd.wr      = 1'b0;
    tbl_cmd.row     = cset_pkg::func_row(stk_res.done_id);
    status_d        = status_q;
    id_d            = id_q;
    excl_d          = excl_q;
    load_res        = 1'b0;
    unique case (state_q)
      cset_pkg::S_IDLE: begin
        evt_i.ready = 1'b1;
        if (evt_acc) begin
          if (evt_i.op == cset_pkg::OP_START) begin
            stk_cmd.push = !stk_res.full;
            status_d     = cset_pkg::ST_OVER;
          end else begin
            stk_cmd.pop = !stk_res.empty;
            status_d    = stk_res.empty ? cset_pkg::ST_UNDER : cset_pkg::ST_OK;
          end
        end
      end
      cset_pkg::S_STACK: begin
        tbl_cmd.rd = 1'b1;
        id_d       = (status_q == cset_pkg::ST_OK) ? stk_res.done_id : '0;
        excl_d     = (status_q == cset_pkg::ST_OK) ? stk_res.excl : '0;
      end
      cset_pkg::S_TABLE: begin
        load_res   = slot_free;
        tbl_cmd.wr = slot_free && (status_q == cset_pkg::ST_OK);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= cset_pkg::S_IDLE;
      status_q  <= cset_pkg::ST_OK;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
      if (load_res) begin
        out_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    id_q   <= id_d;
    excl_q <= excl_d;
    if (load_res) begin
      out_id_q     <= id_q;
      out_excl_q   <= excl_q;
      out_total_q  <= (status_q == cset_pkg::ST_OK) ? total : '0;
      out_status_q <= status_q;
    end
  end

  assign res_o.valid          = out_vld_q;
  assign res_o.done_id        = out_id_q;
  assign res_o.call_exclusive = out_excl_q;
  assign res_o.running_total  = out_total_q;
  assign res_o.status         = out_status_q;

`ifndef NO_ASSERTIONS
  a_end_reads_stack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_acc && evt_i.op == cset_pkg::OP_END |=> state_q == cset_pkg::S_STACK)
    else $error("end beat did not start a stack read");

  a_push_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stk_cmd.push |=> state_q == cset_pkg::S_IDLE && !$rose(out_vld_q))
    else $error("accepted start produced a result");

  a_err_beat_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_status_q != cset_pkg::ST_OK |->
      out_id_q == '0 && out_excl_q == '0 && out_total_q == '0)
    else $error("flagged beat carries nonzero payload");

  a_table_write_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_cmd.wr |-> state_q == cset_pkg::S_TABLE && status_q == cset_pkg::ST_OK)
    else $error("table write outside the table step");
`endif

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench of the call-stack exclusive-time profiler.
module testbench;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 16;
  localparam int RANDOM_ITEMS   = 960;
  localparam int LONG_CALLS     = 16;

  localparam logic [cset_pkg::EXCL_W-1:0]  SUB_MAX   = '1;
  localparam logic [cset_pkg::TOTAL_W-1:0] TOTAL_MAX = '1;
  localparam logic [cset_pkg::STAMP_W-1:0] STAMP_MAX = '1;

  typedef struct packed {
    logic [cset_pkg::FUNC_W-1:0]  done_id;
    logic [cset_pkg::EXCL_W-1:0]  excl;
    logic [cset_pkg::TOTAL_W-1:0] total;
    cset_pkg::status_e            status;
  } call_report_t;

  logic clk = 1'b0;
  logic rst_n;

  cset_evt_if evt ();
  cset_res_if res ();

  call_stack_exclusive_time u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .evt_i  (evt),
    .res_o  (res)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predicted state of the profiler.
  logic [cset_pkg::FUNC_W-1:0]  open_func  [cset_pkg::STACK_DEPTH];
  logic [cset_pkg::STAMP_W-1:0] open_start [cset_pkg::STACK_DEPTH];
  logic [cset_pkg::EXCL_W-1:0]  open_sub   [cset_pkg::STACK_DEPTH];
  int                           open_depth;
  logic [cset_pkg::TOTAL_W-1:0] excl_totals [cset_pkg::NUM_FUNCS];
  call_report_t                 call_reports [$];

  int                           sender_idle_pct;
  int                           recv_idle_pct;
  int                           mismatches;
  logic [cset_pkg::STAMP_W-1:0] trace_clock;

  // Works out the result of one accepted event and updates the predicted state.
  task automatic profile_event(input logic op, input logic [cset_pkg::FUNC_W-1:0] fid,
                               input logic [cset_pkg::STAMP_W-1:0] stamp);
    call_report_t                 rep;
    logic [cset_pkg::STAMP_W-1:0] diff;
    logic [cset_pkg::EXCL_W-1:0]  incl;
    logic [cset_pkg::EXCL_W-1:0]  sub;
    logic [cset_pkg::EXCL_W-1:0]  excl;
    logic [63:0]                  sum;
    int                           top;
    int                           row;
    rep.done_id = '0;
    rep.excl    = '0;
    rep.total   = '0;
    rep.status  = cset_pkg::ST_OK;
    if (op == cset_pkg::OP_START) begin
      if (open_depth >= cset_pkg::STACK_DEPTH) begin
        rep.status = cset_pkg::ST_OVER;
        call_reports.push_back(rep);
      end else begin
        open_func[open_depth]  = fid;
        open_start[open_depth] = stamp;
        open_sub[open_depth]   = '0;
        open_depth++;
      end
    end else if (open_depth == 0) begin
      rep.status = cset_pkg::ST_UNDER;
      call_reports.push_back(rep);
    end else begin
      top  = open_depth - 1;
      // The stamp difference wraps at 32 bits before the extra tick is added.
      diff = stamp - open_start[top];
      incl = {1'b0, diff} + cset_pkg::EXCL_W'(1);
      sub  = open_sub[top];
      excl = (sub > incl) ? '0 : incl - sub;
      open_depth = top;
      if (top > 0) begin
        sum = 64'(open_sub[top-1]) + 64'(incl);
        open_sub[top-1] = (sum > 64'(SUB_MAX)) ? SUB_MAX : cset_pkg::EXCL_W'(sum);
      end
      row = int'(open_func[top]) % cset_pkg::NUM_FUNCS;
      sum = 64'(excl_totals[row]) + 64'(excl);
      excl_totals[row] = (sum > 64'(TOTAL_MAX)) ? TOTAL_MAX : cset_pkg::TOTAL_W'(sum);
      rep.done_id = open_func[top];
      rep.excl    = excl;
      rep.total   = excl_totals[row];
      call_reports.push_back(rep);
    end
  endtask

  // Presents one event beat, with random gaps ahead of it, and waits until it is taken.
  task automatic send_event(input logic op, input logic [cset_pkg::FUNC_W-1:0] fid,
                            input logic [cset_pkg::STAMP_W-1:0] stamp);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      evt.valid <= 1'b0;
      @(negedge clk);
    end
    evt.valid   <= 1'b1;
    evt.op      <= op;
    evt.func_id <= fid;
    evt.stamp   <= stamp;
    do @(posedge clk); while (!evt.ready);
    profile_event(op, fid, stamp);
  endtask

  // Holds the sender off until every predicted result beat has come back.
  task automatic wait_for_reports();
    @(negedge clk);
    evt.valid <= 1'b0;
    while (call_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_edge_cases();
    send_event(cset_pkg::OP_END, 8'hFF, STAMP_MAX);    // end with nothing open
    send_event(cset_pkg::OP_START, 8'h00, '0);
    send_event(cset_pkg::OP_END, 8'hAA, '0);            // shortest call, one tick
    send_event(cset_pkg::OP_START, 8'hFF, STAMP_MAX);
    send_event(cset_pkg::OP_END, 8'h55, '0);            // stamp wraps around
    send_event(cset_pkg::OP_START, 8'h01, '0);
    send_event(cset_pkg::OP_END, 8'h01, STAMP_MAX);     // longest call
    // The child wraps to a huge time, so the parent's exclusive time clamps to zero.
    send_event(cset_pkg::OP_START, 8'h02, 32'd1000);
    send_event(cset_pkg::OP_START, 8'h03, 32'd50);
    send_event(cset_pkg::OP_END, 8'h00, 32'd40);
    send_event(cset_pkg::OP_END, 8'h00, 32'd1001);
    send_event(cset_pkg::OP_START, 8'h04, 32'd10);
    send_event(cset_pkg::OP_START, 8'h05, 32'd20);
    send_event(cset_pkg::OP_END, 8'hFF, 32'd29);
    send_event(cset_pkg::OP_START, 8'h06, 32'd30);
    send_event(cset_pkg::OP_END, 8'h80, 32'd30);
    send_event(cset_pkg::OP_END, 8'h7F, 32'd40);
  endtask

  task automatic test_subcall_saturation();
    send_event(cset_pkg::OP_START, 8'h07, '0);
    repeat (3) begin
      send_event(cset_pkg::OP_START, 8'h08, '0);
      send_event(cset_pkg::OP_END, 8'h08, STAMP_MAX);
    end
    send_event(cset_pkg::OP_END, 8'h07, 32'd5);
  endtask

  task automatic test_stack_limits();
    while (open_depth < cset_pkg::STACK_DEPTH)
      send_event(cset_pkg::OP_START, 8'($urandom_range(255)),
                 trace_clock + 32'(open_depth));
    send_event(cset_pkg::OP_START, 8'h11, trace_clock);   // dropped, stack is full
    while (open_depth > 0)
      send_event(cset_pkg::OP_END, 8'($urandom_range(255)),
                 trace_clock + 32'd200 - 32'(open_depth));
    send_event(cset_pkg::OP_END, 8'h22, trace_clock);
  endtask

  // Mostly well-formed call nesting with random ids and times, plus
  // unbalanced ends, overflowing starts and scattered stamps.
  task automatic test_random_trace(input int count);
    int   depth_goal;
    logic is_end;
    logic [cset_pkg::FUNC_W-1:0]  fid;
    logic [cset_pkg::STAMP_W-1:0] stamp;
    depth_goal = 4;
    repeat (count) begin
      if ($urandom_range(99) < 4)
        depth_goal = ($urandom_range(99) < 70) ? $urandom_range(8)
                                               : $urandom_range(cset_pkg::STACK_DEPTH + 2);
      if (open_depth == 0)
        is_end = ($urandom_range(99) < 8);
      else if (open_depth < depth_goal)
        is_end = ($urandom_range(99) < 25);
      else
        is_end = ($urandom_range(99) < 75);
      fid = ($urandom_range(1) == 0) ? 8'($urandom_range(7)) : 8'($urandom_range(255));
      if ($urandom_range(99) < 8) begin
        stamp = $urandom;
      end else begin
        trace_clock = trace_clock + 32'($urandom_range(3000));
        stamp = trace_clock;
      end
      send_event(is_end ? cset_pkg::OP_END : cset_pkg::OP_START, fid, stamp);
    end
  endtask

  // Repeats the longest call on one id so that its running total grows large.
  task automatic test_long_calls();
    while (open_depth > 0) send_event(cset_pkg::OP_END, 8'h00, trace_clock);
    repeat (LONG_CALLS) begin
      send_event(cset_pkg::OP_START, 8'hA5, '0);
      send_event(cset_pkg::OP_END, 8'hA5, STAMP_MAX);
    end
  endtask

  always @(negedge clk) res.ready <= ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk) begin
    call_report_t want;
    if (res.valid && res.ready) begin
      if (call_reports.size() == 0) begin
        $error("result beat with none predicted: done_id %0h status %0d",
               res.done_id, res.status);
        mismatches++;
      end else begin
        want = call_reports.pop_front();
        if (res.done_id !== want.done_id) begin
          $error("done_id: expected %0h, got %0h", want.done_id, res.done_id);
          mismatches++;
        end
        if (res.call_exclusive !== want.excl) begin
          $error("call_exclusive: expected %0h, got %0h", want.excl, res.call_exclusive);
          mismatches++;
        end
        if (res.running_total !== want.total) begin
          $error("running_total: expected %0h, got %0h", want.total, res.running_total);
          mismatches++;
        end
        if (res.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, res.status);
          mismatches++;
        end
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((evt.valid && evt.ready) || (res.valid && res.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("call_stack_exclusive_time verification failed");
    $finish;
  end

  initial begin
    rst_n           = 1'b0;
    evt.valid       = 1'b0;
    evt.op          = cset_pkg::OP_START;
    evt.func_id     = '0;
    evt.stamp       = '0;
    mismatches      = 0;
    open_depth      = 0;
    trace_clock     = $urandom;
    sender_idle_pct = 38;
    recv_idle_pct   = 51;
    for (int i = 0; i < cset_pkg::NUM_FUNCS; i++) excl_totals[i] = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    test_edge_cases();
    test_subcall_saturation();
    test_stack_limits();
    test_random_trace(RANDOM_ITEMS / 3);
    wait_for_reports();

    sender_idle_pct = 51;
    recv_idle_pct   = 38;
    test_random_trace(RANDOM_ITEMS / 3);
    wait_for_reports();

    sender_idle_pct = 0;
    recv_idle_pct   = 0;
    test_random_trace(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
    test_long_calls();
    wait_for_reports();

    if (mismatches == 0 && call_reports.size() == 0) begin
      $display("call_stack_exclusive_time verification clean");
    end else begin
      $display("call_stack_exclusive_time verification failed");
    end
    $finish;
  end

endmodule
